// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked only while a transaction is presented
`define ASSERT_VALID(label, clk, rst_n, vld, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/pses_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pses_pkg
// Types and constants of the power stage enable sequencer: stream item
// layouts, register indexes and ASCII codes.
// ----------------------------------------------------------------------------
package pses_pkg;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;

    typedef enum logic [2:0] {
        REG_MAX_SETPOINT     = 3'd0,
        REG_DC_OK_DELAY      = 3'd1,
        REG_PFC_DELAY        = 3'd2,
        REG_INRUSH_DELAY     = 3'd3,
        REG_FAN_OFF_DELAY    = 3'd4,
        REG_TACHO_WINDOW     = 3'd5,
        REG_TACHO_MIN_PULSES = 3'd6
    } reg_index_t;

    // input item, first field in the lowest bits (112 bits)
    typedef struct packed {
        logic [3:0]  pad;
        logic [11:0] iout_sample;
        logic [11:0] vout_sample;
        logic [3:0]  tacho2_pulses;
        logic [3:0]  tacho1_pulses;
        logic        transformer_hot;
        logic        heatsink_hot;
        logic        comm_error;
        logic        dc_ok_level;
        logic [7:0]  enable_char;
        logic [31:0] voltage_text;
        logic [31:0] current_text;
    } in_item_t;

    // result item, first field in the lowest bits (64 bits)
    typedef struct packed {
        logic [6:0]  pad;
        logic        fan2_fault;
        logic        fan1_fault;
        logic [23:0] power_out;
        logic        dc_good;
        logic        dc_error_led;
        logic        stage_led_on;
        logic        stage_on;
        logic        inrush_on;
        logic        pfc_on;
        logic        fan_on;
        logic [11:0] current_dac;
        logic [11:0] voltage_dac;
    } out_item_t;

endpackage

// ----- hw/rtl/power_stage_enable_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_stage_enable_sequencer
// Per control tick: setpoint text decode and clamp, DC-OK debounce, fan /
// PFC / inrush / main stage enable sequencing, fan-off delay, tacho fault
// windows and output power.
// ----------------------------------------------------------------------------
//  channel    | direction | transaction
//  s_axis     | in        | one control tick (112-bit tdata)
//  m_axis     | out       | one result per tick (64-bit tdata)
//  apb        | in        | register write / read, 7 registers at 4*i
//
//  one tick per cycle while m_axis does not stall; an accepted tick's result
//  reaches m_axis through the input register, then the result register
//  the whole tick update sits between the input and result registers
//  s_axis_tready drops only when both registers hold and m_axis stalls
//  rst_n clears state, pins and registers to their defaults
// ----------------------------------------------------------------------------
module power_stage_enable_sequencer #(
    parameter int DAC_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // current_text, voltage_text, enable_char, dc_ok_level, comm_error,
    // heatsink_hot, transformer_hot, tacho1_pulses, tacho2_pulses,
    // vout_sample, iout_sample, zero pad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // voltage_dac, current_dac, fan_on, pfc_on, inrush_on, stage_on,
    // stage_led_on, dc_error_led, dc_good, power_out, fan1_fault,
    // fan2_fault, zero pad
    output logic [63:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DAC_MAX = (1 << DAC_BITS) - 1;

    // configuration
    logic [11:0] max_setpoint_reg;
    logic [15:0] dc_ok_delay_reg;
    logic [15:0] pfc_delay_reg;
    logic [15:0] inrush_delay_reg;
    logic [15:0] fan_off_delay_reg;
    logic [15:0] tacho_window_reg;
    logic [15:0] tacho_min_pulses_reg;

    // pipeline
    pses_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    pses_pkg::out_item_t out_reg;
    pses_pkg::out_item_t out_next;
    logic                out_valid_reg;
    logic                advance;
    logic                step;

    // sequencer state
    logic [15:0] dc_good_count_reg, dc_good_count_next;
    logic        dc_good_flag_reg, dc_good_flag_next;
    logic [15:0] pfc_count_reg, pfc_count_next;
    logic        pfc_flag_reg, pfc_flag_next;
    logic [15:0] inrush_count_reg, inrush_count_next;
    logic        inrush_flag_reg, inrush_flag_next;
    logic [16:0] fan_off_count_reg, fan_off_count_next;
    logic        heatsink_flag_reg;
    logic        transformer_flag_reg;
    logic [16:0] tacho_window_count_reg [2];
    logic [16:0] tacho_window_count_next [2];
    logic [15:0] tacho_pulse_count_reg [2];
    logic [15:0] tacho_pulse_count_next [2];
    logic        fan_fault_reg [2];
    logic        fan_fault_next [2];

    // pin levels
    logic fan_pin_reg, fan_pin_next;
    logic pfc_pin_reg, pfc_pin_next;
    logic inrush_pin_reg, inrush_pin_next;
    logic stage_pin_reg, stage_pin_next;
    logic led_pin_reg, led_pin_next;
    logic dcerr_pin_reg, dcerr_pin_next;

    // tick datapath
    logic [11:0] lim;
    logic [11:0] cur_sp;
    logic [11:0] volt_sp;
    logic        en_one;
    logic        en_any;
    logic        run;
    logic        zero_sp;
    logic [16:0] dc_count_inc;
    logic [3:0]  tacho_in [2];
    logic [16:0] tacho_sum [2];
    logic [15:0] tacho_sat [2];
    logic [16:0] tacho_win_inc [2];
    logic        apb_write;

    function automatic logic [11:0] decode_text(
        input logic [31:0] text,
        input logic [11:0] limit
    );
        logic signed [9:0]  d3;
        logic signed [9:0]  d2;
        logic signed [9:0]  d1;
        logic signed [9:0]  d0;
        logic signed [19:0] acc;
        logic [11:0]        res;
        d3 = $signed({2'b00, text[31:24]}) - $signed({2'b00, pses_pkg::ASCII_ZERO});
        d2 = $signed({2'b00, text[23:16]}) - $signed({2'b00, pses_pkg::ASCII_ZERO});
        d1 = $signed({2'b00, text[15:8]})  - $signed({2'b00, pses_pkg::ASCII_ZERO});
        d0 = $signed({2'b00, text[7:0]})   - $signed({2'b00, pses_pkg::ASCII_ZERO});
        acc = (20'(d3) * 20'sd1000) + (20'(d2) * 20'sd100)
            + (20'(d1) * 20'sd10) + 20'(d0);
        if (acc < 20'sd0)
        begin
            res = '0;
        end
        else if (acc > $signed({8'd0, limit}))
        begin
            res = limit;
        end
        else
        begin
            res = acc[11:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (pses_pkg::reg_index_t'(paddr[4:2]))
            pses_pkg::REG_MAX_SETPOINT:     prdata = {20'd0, max_setpoint_reg};
            pses_pkg::REG_DC_OK_DELAY:      prdata = {16'd0, dc_ok_delay_reg};
            pses_pkg::REG_PFC_DELAY:        prdata = {16'd0, pfc_delay_reg};
            pses_pkg::REG_INRUSH_DELAY:     prdata = {16'd0, inrush_delay_reg};
            pses_pkg::REG_FAN_OFF_DELAY:    prdata = {16'd0, fan_off_delay_reg};
            pses_pkg::REG_TACHO_WINDOW:     prdata = {16'd0, tacho_window_reg};
            pses_pkg::REG_TACHO_MIN_PULSES: prdata = {16'd0, tacho_min_pulses_reg};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_setpoint_reg     <= 12'd4095;
            dc_ok_delay_reg      <= 16'd100;
            pfc_delay_reg        <= 16'd100;
            inrush_delay_reg     <= 16'd100;
            fan_off_delay_reg    <= 16'd1000;
            tacho_window_reg     <= 16'd1000;
            tacho_min_pulses_reg <= 16'd50;
        end
        else if (apb_write)
        begin
            case (pses_pkg::reg_index_t'(paddr[4:2]))
                pses_pkg::REG_MAX_SETPOINT:     max_setpoint_reg     <= pwdata[11:0];
                pses_pkg::REG_DC_OK_DELAY:      dc_ok_delay_reg      <= pwdata[15:0];
                pses_pkg::REG_PFC_DELAY:        pfc_delay_reg        <= pwdata[15:0];
                pses_pkg::REG_INRUSH_DELAY:     inrush_delay_reg     <= pwdata[15:0];
                pses_pkg::REG_FAN_OFF_DELAY:    fan_off_delay_reg    <= pwdata[15:0];
                pses_pkg::REG_TACHO_WINDOW:     tacho_window_reg     <= pwdata[15:0];
                pses_pkg::REG_TACHO_MIN_PULSES: tacho_min_pulses_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tick update
    // ------------------------------------------------------------------
    // setpoint clamp is the lower of the register and the DAC full scale
    assign lim = ({20'd0, max_setpoint_reg} < 32'(DAC_MAX)) ? max_setpoint_reg
                                                             : 12'(DAC_MAX);
    assign cur_sp  = decode_text(in_reg.current_text, lim);
    assign volt_sp = decode_text(in_reg.voltage_text, lim);
    assign en_one  = (in_reg.enable_char == pses_pkg::ASCII_ONE);
    assign en_any  = (in_reg.enable_char != pses_pkg::ASCII_ZERO);
    assign run     = !in_reg.comm_error && en_one && !transformer_flag_reg
                     && !heatsink_flag_reg;
    assign dc_count_inc = {1'b0, dc_good_count_reg} + 17'd1;

    always_comb
    begin
        dc_good_count_next = dc_good_count_reg;
        dc_good_flag_next  = dc_good_flag_reg;
        pfc_count_next     = pfc_count_reg;
        pfc_flag_next      = pfc_flag_reg;
        inrush_count_next  = inrush_count_reg;
        inrush_flag_next   = inrush_flag_reg;
        fan_off_count_next = fan_off_count_reg;
        fan_pin_next       = fan_pin_reg;
        pfc_pin_next       = pfc_pin_reg;
        inrush_pin_next    = inrush_pin_reg;
        stage_pin_next     = stage_pin_reg;
        led_pin_next       = led_pin_reg;
        dcerr_pin_next     = dcerr_pin_reg;
        zero_sp            = 1'b0;

        // dc-ok debounce, pin level low means good
        if (!in_reg.dc_ok_level)
        begin
            if (dc_count_inc >= {1'b0, dc_ok_delay_reg})
            begin
                dc_good_flag_next  = 1'b1;
                dc_good_count_next = dc_ok_delay_reg;
                dcerr_pin_next     = 1'b0;
            end
            else
            begin
                dc_good_count_next = dc_count_inc[15:0];
            end
        end
        else
        begin
            dc_good_count_next = '0;
            dc_good_flag_next  = 1'b0;
            zero_sp            = 1'b1;
            dcerr_pin_next     = 1'b1;
        end

        if (run)
        begin
            fan_pin_next = 1'b1;
            if (pfc_count_reg < pfc_delay_reg)
            begin
                pfc_count_next = pfc_count_reg + 16'd1;
            end
            else
            begin
                pfc_flag_next  = 1'b1;
                pfc_count_next = pfc_delay_reg;
                pfc_pin_next   = 1'b1;
            end
            fan_off_count_next = '0;
            if (!fan_fault_reg[0] && !fan_fault_reg[1] && dc_good_flag_next
                && pfc_flag_next)
            begin
                if (inrush_count_reg < inrush_delay_reg)
                begin
                    inrush_count_next = inrush_count_reg + 16'd1;
                end
                else
                begin
                    inrush_count_next = inrush_delay_reg;
                    inrush_pin_next   = 1'b1;
                    inrush_flag_next  = 1'b1;
                end
                // with a zero setpoint stage and led keep their level
                if (inrush_flag_next && !zero_sp && (cur_sp != '0) && (volt_sp != '0))
                begin
                    stage_pin_next = 1'b1;
                    led_pin_next   = 1'b1;
                end
                else
                begin
                    zero_sp = 1'b1;
                end
            end
            else
            begin
                if (dc_good_count_next >= dc_ok_delay_reg)
                begin
                    pfc_pin_next = 1'b0;
                end
                inrush_pin_next = 1'b0;
                stage_pin_next  = 1'b0;
                led_pin_next    = 1'b0;
                zero_sp         = 1'b1;
            end
        end
        else
        begin
            pfc_pin_next      = 1'b0;
            inrush_pin_next   = 1'b0;
            stage_pin_next    = 1'b0;
            led_pin_next      = 1'b0;
            inrush_count_next = '0;
            inrush_flag_next  = 1'b0;
            pfc_count_next    = '0;
            pfc_flag_next     = 1'b0;
            if (fan_off_count_reg > {1'b0, fan_off_delay_reg})
            begin
                fan_pin_next       = 1'b0;
                fan_off_count_next = '0;
            end
            else
            begin
                fan_off_count_next = fan_off_count_reg + 17'd1;
            end
            zero_sp = 1'b1;
        end
    end

    // tacho monitors, one lane per fan
    assign tacho_in[0] = in_reg.tacho1_pulses;
    assign tacho_in[1] = in_reg.tacho2_pulses;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            tacho_sum[i]     = {1'b0, tacho_pulse_count_reg[i]} + {13'd0, tacho_in[i]};
            tacho_sat[i]     = tacho_sum[i][16] ? 16'hFFFF : tacho_sum[i][15:0];
            tacho_win_inc[i] = tacho_window_count_reg[i] + 17'd1;
            tacho_pulse_count_next[i]  = tacho_sat[i];
            tacho_window_count_next[i] = tacho_win_inc[i];
            fan_fault_next[i]          = fan_fault_reg[i];
            if (tacho_win_inc[i] > {1'b0, tacho_window_reg})
            begin
                tacho_window_count_next[i] = '0;
                if (tacho_sat[i] < tacho_min_pulses_reg)
                begin
                    // a slow fan only counts as faulty while enabled
                    if (en_any)
                    begin
                        fan_fault_next[i]         = 1'b1;
                        tacho_pulse_count_next[i] = '0;
                    end
                end
                else
                begin
                    fan_fault_next[i]         = 1'b0;
                    tacho_pulse_count_next[i] = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_next              = '0;
        out_next.voltage_dac  = zero_sp ? 12'd0 : volt_sp;
        out_next.current_dac  = zero_sp ? 12'd0 : cur_sp;
        out_next.fan_on       = fan_pin_next;
        out_next.pfc_on       = pfc_pin_next;
        out_next.inrush_on    = inrush_pin_next;
        out_next.stage_on     = stage_pin_next;
        out_next.stage_led_on = led_pin_next;
        out_next.dc_error_led = dcerr_pin_next;
        out_next.dc_good      = dc_good_flag_next;
        out_next.power_out    = 24'(in_reg.vout_sample) * 24'(in_reg.iout_sample);
        out_next.fan1_fault   = fan_fault_next[0];
        out_next.fan2_fault   = fan_fault_next[1];
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= pses_pkg::in_item_t'(s_axis_tdata);
        end
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_good_count_reg    <= '0;
            dc_good_flag_reg     <= 1'b0;
            pfc_count_reg        <= '0;
            pfc_flag_reg         <= 1'b0;
            inrush_count_reg     <= '0;
            inrush_flag_reg      <= 1'b0;
            fan_off_count_reg    <= '0;
            heatsink_flag_reg    <= 1'b0;
            transformer_flag_reg <= 1'b0;
            fan_pin_reg          <= 1'b0;
            pfc_pin_reg          <= 1'b0;
            inrush_pin_reg       <= 1'b0;
            stage_pin_reg        <= 1'b0;
            led_pin_reg          <= 1'b0;
            dcerr_pin_reg        <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                tacho_window_count_reg[i] <= '0;
                tacho_pulse_count_reg[i]  <= '0;
                fan_fault_reg[i]          <= 1'b0;
            end
        end
        else if (step)
        begin
            dc_good_count_reg    <= dc_good_count_next;
            dc_good_flag_reg     <= dc_good_flag_next;
            pfc_count_reg        <= pfc_count_next;
            pfc_flag_reg         <= pfc_flag_next;
            inrush_count_reg     <= inrush_count_next;
            inrush_flag_reg      <= inrush_flag_next;
            fan_off_count_reg    <= fan_off_count_next;
            heatsink_flag_reg    <= in_reg.heatsink_hot;
            transformer_flag_reg <= in_reg.transformer_hot;
            fan_pin_reg          <= fan_pin_next;
            pfc_pin_reg          <= pfc_pin_next;
            inrush_pin_reg       <= inrush_pin_next;
            stage_pin_reg        <= stage_pin_next;
            led_pin_reg          <= led_pin_next;
            dcerr_pin_reg        <= dcerr_pin_next;
            for (int i = 0; i < 2; i++)
            begin
                tacho_window_count_reg[i] <= tacho_window_count_next[i];
                tacho_pulse_count_reg[i]  <= tacho_pulse_count_next[i];
                fan_fault_reg[i]          <= fan_fault_next[i];
            end
        end
    end

endmodule

// ----- hw/rtl/pses_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pses_checker
// Port-level checks on the result stream of the power stage enable
// sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pses_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    // voltage_dac, current_dac, fan_on, pfc_on, inrush_on, stage_on,
    // stage_led_on, dc_error_led, dc_good, power_out, fan1_fault,
    // fan2_fault, zero pad
    input logic [63:0] m_axis_tdata
);

    pses_pkg::out_item_t obs;

    assign obs = pses_pkg::out_item_t'(m_axis_tdata);

    // stalled transaction holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // stage and its led move together, and only with fans on and dc good
    `ASSERT_VALID(a_stage_pins, clk, rst_n, m_axis_tvalid, (obs.stage_on == obs.stage_led_on) && (!obs.stage_on || (obs.fan_on && obs.dc_good)), "stage pins out of sequence")

    // a live setpoint needs the main stage on
    `ASSERT_VALID(a_dac_gated, clk, rst_n, m_axis_tvalid, ((obs.voltage_dac == 12'd0) && (obs.current_dac == 12'd0)) || obs.stage_on, "setpoint driven with stage off")

    // dc fault led never lit while dc is accepted as good
    `ASSERT_VALID(a_dc_led, clk, rst_n, m_axis_tvalid, !(obs.dc_good && obs.dc_error_led), "dc error led lit with dc good")

endmodule

bind power_stage_enable_sequencer pses_checker u_pses_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
